// ===== sv/pdah_pkg.sv =====
// pdah_pkg: shared types and constants for the pd altitude hold step block
// word format, sequencer encodings and configuration register indexes
// no dependencies
package pdah_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// tdata width of either stream: three words, padded to whole bytes
	localparam int DATA_BITS = ((3 * WORD_BITS + 7) / 8) * 8;

	// magnitude held before saturation: shifted product or full quotient
	localparam int MAG_BITS = (2 * WORD_BITS - FRAC_BITS > WORD_BITS + FRAC_BITS) ?
		(2 * WORD_BITS - FRAC_BITS) : (WORD_BITS + FRAC_BITS);

	// restoring divider: one quotient bit per cycle
	localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
	localparam int CNT_BITS  = $clog2(DIV_STEPS);
	localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DIV_STEPS - 1);

	localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// 9.81 rounded to the fraction grid, and one half
	localparam logic [WORD_BITS-1:0] GRAV =
		WORD_BITS'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [WORD_BITS-1:0] HALF = WORD_BITS'(64'd1 << (FRAC_BITS - 1));

	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TARGET_ALT  = 3'd0,
		REG_TARGET_VEL  = 3'd1,
		REG_FF_ACCEL    = 3'd2,
		REG_GAIN_PROP   = 3'd3,
		REG_GAIN_DERIV  = 3'd4,
		REG_MASS        = 3'd5,
		REG_TIME_STEP   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		DST_ALT,
		DST_VEL,
		DST_DRV,
		DST_NET,
		DST_T0,
		DST_T1,
		DST_LAW
	} dst_t;

	// microprogram addresses, in execution order
	typedef enum logic [4:0] {
		ST_DT2,
		ST_QUO,
		ST_NET,
		ST_ACC,
		ST_HALF,
		ST_VDT,
		ST_TSUM,
		ST_ALT,
		ST_NDT,
		ST_VEL,
		ST_LAW0,
		ST_EV,
		ST_DTERM,
		ST_LAW1,
		ST_EA,
		ST_PTERM,
		ST_LAW2,
		ST_DRV
	} step_t;

endpackage

// ===== sv/pd_altitude_hold_step.sv =====
// pd_altitude_hold_step: one tick of a pd altitude hold loop on a point mass
// a small sequencer drives one shared multiply / divide / add unit
// depends on pdah_pkg
//
// usage:
//   s_* stream takes one tick per transaction; s_tuser is the restart flag,
//   which loads altitude, velocity and drive from s_tdata before the step.
//   m_* stream returns the new altitude, velocity and drive; m_tuser is set
//   when any operation of the tick clipped to the word range.
//   cfg_* writes one register per cycle with cfg_wen high; write only while
//   the block is idle. unknown indexes are dropped.
// sequence:
//   18 micro-operations run on one unit in turn: a multiply is computed and
//   then saturated and written back, an add or subtract writes back directly,
//   and the divide by mass runs 48 restoring iterations between setup and
//   saturation. with zero mass the divide skips the iterations. the next
//   tick is taken only once the result is handed to the output register.
// reset and stalls:
//   arst_n clears the state words to zero and loads the register defaults
//   (mass 1.0, time step 655/65536 s). the result sits in an output register;
//   the next tick is accepted while it waits, and a finished tick holds in
//   its last state until the output register frees.
module pd_altitude_hold_step
	import pdah_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// init_altitude, init_velocity, init_drive
	input  logic [DATA_BITS-1:0]    s_tdata,
	// restart
	input  logic                    s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// altitude_out, velocity_out, drive_out
	output logic [DATA_BITS-1:0]    m_tdata,
	// saturated
	output logic                    m_tuser,
	input  logic                    cfg_wen,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]    cfg_wdata
);

	localparam int W = WORD_BITS;

	state_t state_q, state_d;
	step_t  step_q;

	logic [W-1:0]   tgt_alt_q, tgt_vel_q, ff_q;
	logic [W-2:0]   gain_p_q, gain_d_q, mass_q, dt_q;
	logic [W-1:0]   alt_q, vel_q, drv_q, net_q, t0_q, t1_q, law_q;
	logic           clip_q;

	logic [MAG_BITS-1:0]  mag_q;
	logic                 sign_q;
	logic [DIV_STEPS-1:0] num_q;
	logic [W-1:0]         rem_q;
	logic [CNT_BITS-1:0]  cnt_q;

	logic [W-1:0]   out_alt_q, out_vel_q, out_drv_q;
	logic           out_sat_q, out_valid_q;

	op_t            op;
	dst_t           dst;
	logic [W-1:0]   opa, opb;

	logic           a_neg, b_neg;
	logic [W-1:0]   a_mag, b_mag;
	logic [2*W-1:0] prod;
	logic [W:0]     sum;
	logic           as_clip;
	logic [W-1:0]   as_res;
	logic           fin_clip;
	logic [W-1:0]   fin_res, fin_mag;
	logic [W:0]     trial;
	logic           ge;
	logic [W:0]     rem_nx;

	logic           accept;
	logic           wb_en, wb_clip, out_load;
	logic [W-1:0]   wb_val;

	// operand select and destination for each microprogram step
	always_comb begin
		op  = OP_ADD;
		dst = DST_T0;
		opa = '0;
		opb = '0;
		unique case (step_q)
			ST_DT2:   begin op = OP_MUL; opa = {1'b0, dt_q};     opb = {1'b0, dt_q};   dst = DST_T1;  end
			ST_QUO:   begin op = OP_DIV; opa = drv_q;            opb = {1'b0, mass_q}; dst = DST_T0;  end
			ST_NET:   begin op = OP_SUB; opa = t0_q;             opb = GRAV;           dst = DST_NET; end
			ST_ACC:   begin op = OP_MUL; opa = net_q;            opb = t1_q;           dst = DST_T0;  end
			ST_HALF:  begin op = OP_MUL; opa = t0_q;             opb = HALF;           dst = DST_T0;  end
			ST_VDT:   begin op = OP_MUL; opa = vel_q;            opb = {1'b0, dt_q};   dst = DST_T1;  end
			ST_TSUM:  begin op = OP_ADD; opa = t0_q;             opb = t1_q;           dst = DST_T0;  end
			ST_ALT:   begin op = OP_ADD; opa = t0_q;             opb = alt_q;          dst = DST_ALT; end
			ST_NDT:   begin op = OP_MUL; opa = net_q;            opb = {1'b0, dt_q};   dst = DST_T0;  end
			ST_VEL:   begin op = OP_ADD; opa = vel_q;            opb = t0_q;           dst = DST_VEL; end
			ST_LAW0:  begin op = OP_ADD; opa = GRAV;             opb = ff_q;           dst = DST_LAW; end
			ST_EV:    begin op = OP_SUB; opa = tgt_vel_q;        opb = vel_q;          dst = DST_T0;  end
			ST_DTERM: begin op = OP_MUL; opa = {1'b0, gain_d_q}; opb = t0_q;           dst = DST_T0;  end
			ST_LAW1:  begin op = OP_ADD; opa = law_q;            opb = t0_q;           dst = DST_LAW; end
			ST_EA:    begin op = OP_SUB; opa = tgt_alt_q;        opb = alt_q;          dst = DST_T0;  end
			ST_PTERM: begin op = OP_MUL; opa = {1'b0, gain_p_q}; opb = t0_q;           dst = DST_T0;  end
			ST_LAW2:  begin op = OP_ADD; opa = law_q;            opb = t0_q;           dst = DST_LAW; end
			ST_DRV:   begin op = OP_MUL; opa = {1'b0, mass_q};   opb = law_q;          dst = DST_DRV; end
			default:  begin op = OP_ADD; opa = '0;               opb = '0;             dst = DST_T0;  end
		endcase
	end

	// shared arithmetic unit
	always_comb begin
		a_neg = opa[W-1];
		b_neg = opb[W-1];
		a_mag = a_neg ? (~opa + 1'b1) : opa;
		b_mag = b_neg ? (~opb + 1'b1) : opb;
		prod  = (2*W)'(a_mag) * (2*W)'(b_mag);

		if (op == OP_SUB) begin
			sum = {opa[W-1], opa} - {opb[W-1], opb};
		end else begin
			sum = {opa[W-1], opa} + {opb[W-1], opb};
		end
		as_clip = sum[W] ^ sum[W-1];
		as_res  = as_clip ? (sum[W] ? WORD_MIN : WORD_MAX) : sum[W-1:0];

		// limit is one larger on the negative side
		fin_clip = mag_q > (MAG_BITS'(WORD_MAX) + MAG_BITS'(sign_q));
		fin_mag  = mag_q[W-1:0];
		if (fin_clip) begin
			fin_res = sign_q ? WORD_MIN : WORD_MAX;
		end else begin
			fin_res = sign_q ? (~fin_mag + 1'b1) : fin_mag;
		end

		trial  = {rem_q, num_q[DIV_STEPS-1]};
		ge     = trial >= {1'b0, b_mag};
		rem_nx = ge ? (trial - {1'b0, b_mag}) : trial;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (op)
					OP_MUL:  state_d = S_FIN;
					OP_DIV:  state_d = (b_mag == '0) ? S_FIN : S_DIV;
					default: state_d = S_EXEC;
				endcase
			end
			S_DIV: begin
				if (cnt_q == DIV_LAST) state_d = S_FIN;
			end
			S_FIN: begin
				state_d = (step_q == ST_DRV) ? S_DONE : S_EXEC;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = (state_q == S_IDLE);
		accept   = s_tvalid && s_tready;
		out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);
		wb_en    = 1'b0;
		wb_val   = as_res;
		wb_clip  = as_clip;
		if (state_q == S_FIN) begin
			wb_en   = 1'b1;
			wb_val  = fin_res;
			wb_clip = fin_clip;
		end else if (state_q == S_EXEC && (op == OP_ADD || op == OP_SUB)) begin
			wb_en = 1'b1;
		end
	end

	// control, configuration and state words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_DT2;
			clip_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			tgt_alt_q   <= '0;
			tgt_vel_q   <= '0;
			ff_q        <= '0;
			gain_p_q    <= '0;
			gain_d_q    <= '0;
			mass_q      <= (W-1)'(64'd1 << FRAC_BITS);
			dt_q        <= (W-1)'(655);
			alt_q       <= '0;
			vel_q       <= '0;
			drv_q       <= '0;
			net_q       <= '0;
			t0_q        <= '0;
			t1_q        <= '0;
			law_q       <= '0;
		end else begin
			state_q <= state_d;

			if (cfg_wen) begin
				unique case (cfg_index)
					REG_TARGET_ALT: tgt_alt_q <= cfg_wdata;
					REG_TARGET_VEL: tgt_vel_q <= cfg_wdata;
					REG_FF_ACCEL:   ff_q      <= cfg_wdata;
					REG_GAIN_PROP:  gain_p_q  <= cfg_wdata[W-2:0];
					REG_GAIN_DERIV: gain_d_q  <= cfg_wdata[W-2:0];
					REG_MASS:       mass_q    <= cfg_wdata[W-2:0];
					REG_TIME_STEP:  dt_q      <= cfg_wdata[W-2:0];
					default: ;
				endcase
			end

			if (accept) begin
				step_q <= ST_DT2;
				clip_q <= 1'b0;
				if (s_tuser) begin
					alt_q <= s_tdata[W-1:0];
					vel_q <= s_tdata[2*W-1:W];
					drv_q <= s_tdata[3*W-1:2*W];
				end
			end

			if (state_q == S_EXEC && op == OP_DIV) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (wb_en) begin
				clip_q <= clip_q | wb_clip;
				if (step_q != ST_DRV) step_q <= step_t'(step_q + 1'b1);
				unique case (dst)
					DST_ALT: alt_q <= wb_val;
					DST_VEL: vel_q <= wb_val;
					DST_DRV: drv_q <= wb_val;
					DST_NET: net_q <= wb_val;
					DST_T0:  t0_q  <= wb_val;
					DST_T1:  t1_q  <= wb_val;
					DST_LAW: law_q <= wb_val;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// unit datapath and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && op == OP_MUL) begin
			mag_q  <= MAG_BITS'(prod >> FRAC_BITS);
			sign_q <= a_neg ^ b_neg;
		end else if (state_q == S_EXEC && op == OP_DIV) begin
			num_q <= {a_mag, FRAC_BITS'(0)};
			rem_q <= '0;
			if (b_mag == '0) begin
				// zero divisor clips a nonzero dividend to the limit with its sign; zero stays zero
				mag_q  <= (a_mag != '0) ? '1 : '0;
				sign_q <= a_neg;
			end else begin
				mag_q  <= '0;
				sign_q <= a_neg ^ b_neg;
			end
		end else if (state_q == S_DIV) begin
			num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
			rem_q <= rem_nx[W-1:0];
			mag_q <= {mag_q[MAG_BITS-2:0], ge};
		end

		if (out_load) begin
			out_alt_q <= alt_q;
			out_vel_q <= vel_q;
			out_drv_q <= drv_q;
			out_sat_q <= clip_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_BITS'({out_drv_q, out_vel_q, out_alt_q});
	assign m_tuser  = out_sat_q;

endmodule

// ===== bench/pd_altitude_hold_step_test.sv =====
// pd_altitude_hold_step_test: self-checking bench for the pd altitude hold step block
// streams ticks under many settings, compares each result with a predictor or a fixed value
// depends on pdah_pkg and pd_altitude_hold_step
module pd_altitude_hold_step_test
	import pdah_pkg::*;
();

	localparam int CLK_PERIOD = 4;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 157;
	localparam int HOLD_PHASE = 1;
	localparam int LONG_HOLD = 600;
	localparam int SETTLE_CYCLES = 100;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	localparam longint GRAVITY = ((64'sd981 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
	localparam longint HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		PRESET_RESET,
		PRESET_HOVER,
		PRESET_ZERO_MASS,
		PRESET_MAX,
		PRESET_MIN,
		PRESET_WILD
	} preset_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] altitude;
		logic [WORD_BITS-1:0] velocity;
		logic [WORD_BITS-1:0] drive;
		logic                 clipped;
	} tick_result_t;

	typedef struct packed {
		preset_t              preset;
		logic                 restart;
		logic [WORD_BITS-1:0] alt;
		logic [WORD_BITS-1:0] vel;
		logic [WORD_BITS-1:0] drv;
		logic                 typed;
		tick_result_t         want;
	} probe_t;

	localparam int PROBE_COUNT = 25;
	localparam probe_t PROBES [PROBE_COUNT] = '{
		// from rest after reset: gravity alone, unit mass, default step
		'{PRESET_RESET, 1'b1, 32'h0, 32'h0, 32'h0, 1'b1,
			'{32'hFFFF_FFE3, 32'hFFFF_E6E7, 32'h0009_CF5C, 1'b0}},
		'{PRESET_RESET, 1'b0, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'hFFFF_0000, 1'b0, '0},
		'{PRESET_RESET, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
		'{PRESET_RESET, 1'b1, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, '0},
		'{PRESET_RESET, 1'b1, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, '0},
		'{PRESET_RESET, 1'b1, WORD_MAX, WORD_MIN, 32'h0, 1'b0, '0},
		'{PRESET_RESET, 1'b1, WORD_MIN, WORD_MAX, 32'h0001_0000, 1'b0, '0},
		'{PRESET_RESET, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
		'{PRESET_HOVER, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{PRESET_HOVER, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0, 1'b0, '0},
		'{PRESET_HOVER, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{PRESET_HOVER, 1'b1, 32'h0064_0000, 32'h0, 32'h000A_0000, 1'b0, '0},
		// zero mass: zero dividend stays zero, otherwise the quotient pins
		'{PRESET_ZERO_MASS, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{PRESET_ZERO_MASS, 1'b1, 32'h0, 32'h0, WORD_MAX, 1'b0, '0},
		'{PRESET_ZERO_MASS, 1'b1, 32'h0, 32'h0, WORD_MIN, 1'b0, '0},
		'{PRESET_ZERO_MASS, 1'b0, 32'h3C3C_C3C3, 32'h0, 32'h0, 1'b0, '0},
		'{PRESET_MAX, 1'b1, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, '0},
		'{PRESET_MAX, 1'b1, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, '0},
		'{PRESET_MAX, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{PRESET_MIN, 1'b1, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, '0},
		'{PRESET_MIN, 1'b1, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, '0},
		'{PRESET_MIN, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{PRESET_WILD, 1'b1, 32'h8765_4321, 32'h0FED_CBA9, 32'hC001_D00D, 1'b0, '0},
		'{PRESET_RESET, 1'b1, 32'h0, 32'h0, 32'h0, 1'b1,
			'{32'hFFFF_FFE3, 32'hFFFF_E6E7, 32'h0009_CF5C, 1'b0}},
		'{PRESET_RESET, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0, '0}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	// init_altitude, init_velocity, init_drive
	logic [DATA_BITS-1:0]    s_tdata;
	// restart
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	// altitude_out, velocity_out, drive_out
	logic [DATA_BITS-1:0]    m_tdata;
	// saturated
	logic                    m_tuser;
	logic                    cfg_wen;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [WORD_BITS-1:0]    cfg_wdata;

	pd_altitude_hold_step u_top (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// plant state and register copy, as the block should hold them
	longint plant_alt = 0;
	longint plant_vel = 0;
	longint plant_drive = 0;
	longint set_alt = 0;
	longint set_vel = 0;
	longint ff_accel = 0;
	longint kp = 0;
	longint kd = 0;
	longint mass = 65536;
	longint dt = 655;
	bit     tick_clipped;

	tick_result_t expected_ticks [$];
	tick_result_t seen;
	tick_result_t owed;

	bit sender_gaps = 1'b0;
	bit sink_stalls = 1'b0;
	bit hold_request = 1'b0;

	int errors = 0;
	int ticks_sent = 0;
	int ticks_checked = 0;
	int restarts_sent = 0;
	int zero_mass_ticks = 0;
	int clipped_ticks = 0;
	int settings_applied = 0;

	function automatic longint clip_word(input bit neg, input longint unsigned magn);
		longint unsigned lim;
		lim = (64'd1 << (WORD_BITS - 1)) - 64'd1 + neg;
		if (magn > lim) begin
			magn = lim;
			tick_clipped = 1'b1;
		end
		return neg ? -longint'(magn) : longint'(magn);
	endfunction

	function automatic longint q_sum(input longint a, input longint b);
		longint s;
		s = a + b;
		return clip_word(s < 0, s < 0 ? -s : s);
	endfunction

	function automatic longint q_prod(input longint a, input longint b);
		longint unsigned ma, mb;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		return clip_word((a < 0) != (b < 0), (ma * mb) >> FRAC_BITS);
	endfunction

	function automatic longint q_quot(input longint a, input longint m);
		longint unsigned ma, mm;
		ma = a < 0 ? -a : a;
		mm = m < 0 ? -m : m;
		// division by zero mass pins a nonzero dividend to the limit with its sign; zero stays zero
		if (mm == 0)
			return (ma == 0) ? 0 : clip_word(a < 0, 64'hFFFF_FFFF_FFFF_FFFF);
		return clip_word((a < 0) != (m < 0), (ma << FRAC_BITS) / mm);
	endfunction

	function automatic tick_result_t advance_plant(input logic restart,
			input logic [WORD_BITS-1:0] a, v, d);
		longint dt2, net, t, law;
		tick_result_t r;
		tick_clipped = 1'b0;
		if (restart) begin
			plant_alt = longint'($signed(a));
			plant_vel = longint'($signed(v));
			plant_drive = longint'($signed(d));
		end
		dt2 = q_prod(dt, dt);
		net = q_sum(q_quot(plant_drive, mass), -GRAVITY);
		t = q_prod(q_prod(net, dt2), HALF_Q);
		t = q_sum(t, q_prod(plant_vel, dt));
		plant_alt = q_sum(t, plant_alt);
		plant_vel = q_sum(plant_vel, q_prod(net, dt));
		law = q_sum(GRAVITY, ff_accel);
		law = q_sum(law, q_prod(kd, q_sum(set_vel, -plant_vel)));
		law = q_sum(law, q_prod(kp, q_sum(set_alt, -plant_alt)));
		plant_drive = q_prod(mass, law);
		r.altitude = plant_alt[WORD_BITS-1:0];
		r.velocity = plant_vel[WORD_BITS-1:0];
		r.drive = plant_drive[WORD_BITS-1:0];
		r.clipped = tick_clipped;
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [WORD_BITS-1:0] val);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_TARGET_ALT: set_alt = longint'($signed(val));
			REG_TARGET_VEL: set_vel = longint'($signed(val));
			REG_FF_ACCEL:   ff_accel = longint'($signed(val));
			REG_GAIN_PROP:  kp = longint'(val[WORD_BITS-2:0]);
			REG_GAIN_DERIV: kd = longint'(val[WORD_BITS-2:0]);
			REG_MASS:       mass = longint'(val[WORD_BITS-2:0]);
			REG_TIME_STEP:  dt = longint'(val[WORD_BITS-2:0]);
			default: ;
		endcase
	endtask

	task automatic apply_preset(input preset_t p);
		logic [WORD_BITS-1:0] w_alt, w_vel, w_ff, w_kp, w_kd, w_mass, w_dt;
		// moderate loop: tens of metres, a few m/s, gains of a few units
		w_alt = $urandom_range(0, 200 << 16) - (100 << 16);
		w_vel = $urandom_range(0, 4 << 16) - (2 << 16);
		w_ff = $urandom_range(0, 2 << 16) - (1 << 16);
		w_kp = $urandom_range(0, 8 << 16);
		w_kd = $urandom_range(0, 6 << 16);
		w_mass = $urandom_range(1 << 14, 8 << 16);
		w_dt = $urandom_range(65, 3277);
		case (p)
			PRESET_RESET: begin
				w_alt = '0;
				w_vel = '0;
				w_ff = '0;
				w_kp = '0;
				w_kd = '0;
				w_mass = 32'd65536;
				w_dt = 32'd655;
			end
			// the top bit of a gain, mass or step register is dropped
			PRESET_ZERO_MASS: w_mass = $urandom_range(0, 1) ? 32'h0 : 32'h8000_0000;
			PRESET_MAX: begin
				w_alt = WORD_MAX;
				w_vel = WORD_MAX;
				w_ff = WORD_MAX;
				w_kp = 32'hFFFF_FFFF;
				w_kd = 32'hFFFF_FFFF;
				w_mass = 32'hFFFF_FFFF;
				w_dt = 32'hFFFF_FFFF;
			end
			PRESET_MIN: begin
				w_alt = WORD_MIN;
				w_vel = WORD_MIN;
				w_ff = WORD_MIN;
				w_kp = '0;
				w_kd = '0;
				w_mass = 32'd1;
				w_dt = 32'd1;
			end
			PRESET_WILD: begin
				w_alt = $urandom;
				w_vel = $urandom;
				w_ff = $urandom;
				w_kp = $urandom;
				w_kd = $urandom;
				w_mass = $urandom;
				w_dt = $urandom;
			end
			default: ;
		endcase
		write_reg(REG_TARGET_ALT, w_alt);
		write_reg(REG_TARGET_VEL, w_vel);
		write_reg(REG_FF_ACCEL, w_ff);
		write_reg(REG_GAIN_PROP, w_kp);
		write_reg(REG_GAIN_DERIV, w_kd);
		write_reg(REG_MASS, w_mass);
		write_reg(REG_TIME_STEP, w_dt);
		write_reg(REG_UNUSED, $urandom);
		settings_applied++;
	endtask

	task automatic send_tick(input logic restart, input logic [WORD_BITS-1:0] a, v, d,
			input logic typed, input tick_result_t want);
		int gap;
		tick_result_t r;
		gap = (sender_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = restart;
		s_tdata = {d, v, a};
		do @(posedge clk); while (!s_tready);
		r = advance_plant(restart, a, v, d);
		expected_ticks.push_back(typed ? want : r);
		ticks_sent++;
		if (restart)
			restarts_sent++;
		if (mass == 0)
			zero_mass_ticks++;
		if (r.clipped)
			clipped_ticks++;
	endtask

	// stop offering and let every outstanding tick come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		do @(posedge clk); while (expected_ticks.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [WORD_BITS-1:0] want, got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// result receiver: random stalls, plus one long hold when asked
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.altitude = m_tdata[WORD_BITS-1:0];
			seen.velocity = m_tdata[2*WORD_BITS-1:WORD_BITS];
			seen.drive = m_tdata[3*WORD_BITS-1:2*WORD_BITS];
			seen.clipped = m_tuser;
			if (expected_ticks.size() == 0) begin
				$error("result with no tick outstanding: %h tuser %b", m_tdata, m_tuser);
				errors++;
			end else begin
				owed = expected_ticks.pop_front();
				ticks_checked++;
				check_field("altitude_out", owed.altitude, seen.altitude);
				check_field("velocity_out", owed.velocity, seen.velocity);
				check_field("drive_out", owed.drive, seen.drive);
				check_field("saturated", WORD_BITS'(owed.clipped), WORD_BITS'(seen.clipped));
			end
		end
	end

	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("pd_altitude_hold_step_test NOT OK");
		$finish;
	end

	initial begin
		preset_t active_preset, pick;
		int run_left;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_TARGET_ALT;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		active_preset = PRESET_RESET;
		for (int i = 0; i < PROBE_COUNT; i++) begin
			if (PROBES[i].preset != active_preset) begin
				wait_drained();
				apply_preset(PROBES[i].preset);
				active_preset = PROBES[i].preset;
			end
			send_tick(PROBES[i].restart, PROBES[i].alt, PROBES[i].vel, PROBES[i].drv,
				PROBES[i].typed, PROBES[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			// no idling at all in the closing phases
			sender_gaps = (ph < PHASES - 2) && ($urandom_range(0, 2) != 0);
			sink_stalls = (ph < PHASES - 2) && ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 9))
				6: pick = PRESET_RESET;
				7: pick = PRESET_ZERO_MASS;
				8: pick = PRESET_WILD;
				9: pick = $urandom_range(0, 1) ? PRESET_MAX : PRESET_MIN;
				default: pick = PRESET_HOVER;
			endcase
			apply_preset(pick);
			run_left = 0;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 6) == 0) begin
					send_tick(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
						1'b0, '0);
				end else if (run_left == 0) begin
					// new flight: plausible altitude, climb rate and thrust
					send_tick(1'b1, $urandom_range(0, 400 << 16) - (200 << 16),
						$urandom_range(0, 40 << 16) - (20 << 16),
						$urandom_range(0, 60 << 16), 1'b0, '0);
					run_left = $urandom_range(4, 40);
				end else begin
					send_tick(1'b0, $urandom, $urandom, $urandom, 1'b0, '0);
					run_left--;
				end
				// output side blocks while ticks keep coming, so the input backs up
				if (ph == HOLD_PHASE && k == ITEMS_PER_PHASE / 2)
					hold_request = 1'b1;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("ticks: %0d sent, %0d checked, %0d restarts, %0d zero mass, %0d clipped",
			ticks_sent, ticks_checked, restarts_sent, zero_mass_ticks, clipped_ticks);
		$display("register settings: %0d, incl. reset values, extremes and zero mass",
			settings_applied);
		if (errors == 0)
			$display("pd_altitude_hold_step_test OK");
		else
			$display("pd_altitude_hold_step_test NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/pdah_pkg.sv
sv/pd_altitude_hold_step.sv
bench/pd_altitude_hold_step_test.sv
